/* rtl/core/exlex_pkg.sv */
// Shared types, constants and byte classification for the expression lexer.
// Depends on nothing; every other file in rtl/core but exlex_ram imports it.
package exlex_pkg;

  // Identifier storage geometry.
  localparam int MaxIdentLen = 63;
  localparam int IdentLenW   = 6;
  localparam int ChunkBytes  = 8;
  localparam int ChunkW      = 64;
  localparam int IdentRows   = 8;
  localparam int RowW        = 3;

  // Token kinds.
  localparam logic [3:0] K_NUMBER  = 4'd0;
  localparam logic [3:0] K_IDENT   = 4'd1;
  localparam logic [3:0] K_PRINT   = 4'd2;
  localparam logic [3:0] K_PLUS    = 4'd3;
  localparam logic [3:0] K_MINUS   = 4'd4;
  localparam logic [3:0] K_STAR    = 4'd5;
  localparam logic [3:0] K_SLASH   = 4'd6;
  localparam logic [3:0] K_EQUAL   = 4'd7;
  localparam logic [3:0] K_LPAREN  = 4'd8;
  localparam logic [3:0] K_RPAREN  = 4'd9;
  localparam logic [3:0] K_NEWLINE = 4'd10;
  localparam logic [3:0] K_EOF     = 4'd11;
  localparam logic [3:0] K_BADCHAR = 4'd12;
  localparam logic [3:0] K_TOOLONG = 4'd13;

  // Scan modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_HALT  = 2'd3;

  // The keyword "print", first character in the low byte.
  localparam logic [39:0] KwPrint = 40'h74_6E_69_72_70;

  // What one byte does on its own, outside any run.
  typedef struct packed {
    logic       tok;
    logic [3:0] kind;
    logic       start_num;
    logic       start_ident;
    logic       halt;
  } lex_t;

  // Commands to the identifier buffer.
  typedef struct packed {
    logic            start;
    logic            append;
    logic [7:0]      data;
    logic [RowW-1:0] pos;
    logic [RowW-1:0] row;
    logic            rd_en;
    logic [RowW-1:0] rd_row;
  } ib_cmd_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Classify a byte that is lexed between tokens.
  function automatic lex_t lex_byte(input logic [7:0] b);
    lex_t l;
    l = '0;
    if (is_digit(b)) begin
      l.start_num = 1'b1;
    end else if (is_alpha(b)) begin
      l.start_ident = 1'b1;
    end else begin
      unique case (b)
        8'h20, 8'h09, 8'h0D: l.tok = 1'b0;
        8'h2B: begin l.tok = 1'b1; l.kind = K_PLUS;    end
        8'h2D: begin l.tok = 1'b1; l.kind = K_MINUS;   end
        8'h2A: begin l.tok = 1'b1; l.kind = K_STAR;    end
        8'h2F: begin l.tok = 1'b1; l.kind = K_SLASH;   end
        8'h3D: begin l.tok = 1'b1; l.kind = K_EQUAL;   end
        8'h28: begin l.tok = 1'b1; l.kind = K_LPAREN;  end
        8'h29: begin l.tok = 1'b1; l.kind = K_RPAREN;  end
        8'h0A: begin l.tok = 1'b1; l.kind = K_NEWLINE; end
        8'h00: begin l.tok = 1'b1; l.kind = K_EOF;     end
        default: begin
          l.tok  = 1'b1;
          l.kind = K_BADCHAR;
          l.halt = 1'b1;
        end
      endcase
    end
    return l;
  endfunction

endpackage

/* rtl/core/expression_lexer_top.sv */
// Expression lexer: one text byte per transfer in, tokens out through one output register.
// Tokens leave via the output register; full identifier chunks are read from the row RAM.
// Throughput: one byte per cycle while the output is free; a byte that closes a number or
// print keyword and has its own token holds the input for the tail state; one that closes
// another identifier holds it through the chunk states and tail, as does out_stall.
// Reset is synchronous, active low; it clears the control state, the RAM is not cleared.
module expression_lexer_top
  import exlex_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_text_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_token_kind,
  output logic signed [31:0] out_number_value,
  output logic [63:0]        out_text_chunk,
  output logic [3:0]         out_chunk_bytes,
  output logic               out_last_of_run
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_CHUNK = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;

  logic [1:0]           st_r, st_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [31:0]          acc_r, acc_nxt;
  logic [IdentLenW-1:0] len_r, len_nxt;
  logic                 skip_r, skip_nxt;
  logic [RowW-1:0]      ptr_r, ptr_nxt;
  logic [7:0]           pend_r, pend_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           kind_r, kind_nxt;
  logic [31:0]          value_r, value_nxt;
  logic [ChunkW-1:0]    chunk_r, chunk_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;

  logic                 out_free, in_xfer;
  lex_t                 lx, lp, ap_lex;
  logic [7:0]           ap_byte;
  logic                 do_apply;
  ib_cmd_t              cmd;
  logic [ChunkW-1:0]    part_chunk, row_data;
  logic [RowW-1:0]      full_rows, last_idx;
  logic                 is_print, from_ram;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((st_r == ST_RUN) && out_free);
  assign in_xfer  = in_valid && !in_stall;

  assign lx = lex_byte(in_text_byte);
  assign lp = lex_byte(pend_r);

  // Chunk geometry of the identifier that is being sent.
  assign full_rows = len_r[IdentLenW-1:RowW];
  assign last_idx  = (len_r[RowW-1:0] != '0) ? full_rows : full_rows - RowW'(1);
  assign from_ram  = ptr_r < full_rows;
  assign is_print  = (len_r == IdentLenW'(5)) && (part_chunk[39:0] == KwPrint);

  // Main lexing and emission logic.
  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    skip_nxt  = skip_r;
    ptr_nxt   = ptr_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    do_apply  = 1'b0;
    ap_lex    = lx;
    ap_byte   = in_text_byte;

    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;

    cmd.data = in_text_byte;
    cmd.pos  = len_r[RowW-1:0];
    cmd.row  = len_r[IdentLenW-1:RowW];

    unique case (st_r)
      ST_RUN: begin
        if (in_xfer) begin
          unique case (mode_r)
            MODE_HALT: begin
              mode_nxt = MODE_HALT;
            end
            MODE_NUM: begin
              if (is_digit(in_text_byte)) begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, in_text_byte[3:0]};
              end else begin
                out_valid_nxt = 1'b1;
                kind_nxt  = K_NUMBER;
                value_nxt = acc_r;
                chunk_nxt = '0;
                cnt_nxt   = '0;
                last_nxt  = !lx.tok;
                acc_nxt   = '0;
                if (lx.tok) begin
                  pend_nxt = in_text_byte;
                  st_nxt   = ST_TAIL;
                end else begin
                  do_apply = 1'b1;
                end
              end
            end
            MODE_IDENT: begin
              if (is_digit(in_text_byte) || is_alpha(in_text_byte)) begin
                if (!skip_r) begin
                  if (len_r < IdentLenW'(MaxIdentLen)) begin
                    cmd.append = 1'b1;
                    len_nxt    = len_r + IdentLenW'(1);
                  end else begin
                    out_valid_nxt = 1'b1;
                    kind_nxt  = K_TOOLONG;
                    value_nxt = '0;
                    chunk_nxt = '0;
                    cnt_nxt   = '0;
                    last_nxt  = 1'b1;
                    skip_nxt  = 1'b1;
                    len_nxt   = '0;
                  end
                end
              end else if (skip_r) begin
                do_apply = 1'b1;
              end else if (is_print) begin
                out_valid_nxt = 1'b1;
                kind_nxt  = K_PRINT;
                value_nxt = '0;
                chunk_nxt = '0;
                cnt_nxt   = '0;
                last_nxt  = !lx.tok;
                len_nxt   = '0;
                if (lx.tok) begin
                  pend_nxt = in_text_byte;
                  st_nxt   = ST_TAIL;
                end else begin
                  do_apply = 1'b1;
                end
              end else begin
                // Start reading the first stored row for the chunk sequence.
                pend_nxt   = in_text_byte;
                ptr_nxt    = '0;
                cmd.rd_en  = 1'b1;
                cmd.rd_row = '0;
                st_nxt     = ST_CHUNK;
              end
            end
            default: begin
              do_apply = 1'b1;
            end
          endcase
        end
      end
      ST_CHUNK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt  = K_IDENT;
          value_nxt = '0;
          chunk_nxt = from_ram ? row_data : part_chunk;
          cnt_nxt   = from_ram ? 4'(ChunkBytes) : {1'b0, len_r[RowW-1:0]};
          if (ptr_r == last_idx) begin
            last_nxt = !lp.tok;
            st_nxt   = ST_TAIL;
          end else begin
            last_nxt   = 1'b0;
            ptr_nxt    = ptr_r + RowW'(1);
            cmd.rd_en  = 1'b1;
            cmd.rd_row = ptr_r + RowW'(1);
          end
        end
      end
      default: begin
        // Lex the byte that ended the run.
        ap_lex  = lp;
        ap_byte = pend_r;
        if (!lp.tok || out_free) begin
          do_apply = 1'b1;
          st_nxt   = ST_RUN;
        end
      end
    endcase

    // A byte lexed between tokens: its own token and the run it may start.
    if (do_apply) begin
      skip_nxt = 1'b0;
      acc_nxt  = ap_lex.start_num ? {28'd0, ap_byte[3:0]} : '0;
      len_nxt  = ap_lex.start_ident ? IdentLenW'(1) : '0;
      if (ap_lex.halt) begin
        mode_nxt = MODE_HALT;
      end else if (ap_lex.start_num) begin
        mode_nxt = MODE_NUM;
      end else if (ap_lex.start_ident) begin
        mode_nxt = MODE_IDENT;
      end else begin
        mode_nxt = MODE_IDLE;
      end
      cmd.start = ap_lex.start_ident;
      cmd.data  = ap_byte;
      if (ap_lex.tok) begin
        out_valid_nxt = 1'b1;
        kind_nxt  = ap_lex.kind;
        value_nxt = ap_lex.halt ? {24'd0, ap_byte} : '0;
        chunk_nxt = '0;
        cnt_nxt   = '0;
        last_nxt  = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      mode_r      <= MODE_IDLE;
      acc_r       <= '0;
      len_r       <= '0;
      skip_r      <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      len_r       <= len_nxt;
      skip_r      <= skip_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    chunk_r <= chunk_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
  end

  exlex_ident_buf u_ident_buf (
    .clk       (clk),
    .cmd       (cmd),
    .part_chunk(part_chunk),
    .row_data  (row_data)
  );

  assign out_valid        = out_valid_r;
  assign out_token_kind   = kind_r;
  assign out_number_value = value_r;
  assign out_text_chunk   = chunk_r;
  assign out_chunk_bytes  = cnt_r;
  assign out_last_of_run  = last_r;

  // Identifier length never passes the storage limit.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IdentLenW'(MaxIdentLen))
    else $error("identifier length beyond limit");

  // Identifier chunks carry one to eight bytes; other tokens carry none.
  a_chunk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_IDENT) |-> (out_chunk_bytes != 4'd0) &&
    (out_chunk_bytes <= 4'(ChunkBytes)))
    else $error("bad identifier chunk byte count");

  a_chunk_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != K_IDENT) |-> (out_chunk_bytes == 4'd0))
    else $error("non-identifier token with chunk bytes");

  // Once halted, a transfer leaves the lexer halted and loads no token.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (mode_r == MODE_HALT) |=> (mode_r == MODE_HALT) && (st_r == ST_RUN) &&
    !(out_valid && !$past(out_valid && out_stall)))
    else $error("halted lexer produced a token");

  // The chunk sequence never starts without a stored identifier.
  a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHUNK) |-> (len_r != '0) && (ptr_r <= last_idx))
    else $error("chunk pointer out of range");

endmodule

/* rtl/core/exlex_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module exlex_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/exlex_ident_buf.sv */
// Identifier buffer: assembles bytes into 8-byte rows and stores full rows in a RAM.
// Depends on exlex_pkg and exlex_ram.
module exlex_ident_buf
  import exlex_pkg::*;
(
  input  logic              clk,
  input  ib_cmd_t           cmd,
  output logic [ChunkW-1:0] part_chunk,
  output logic [ChunkW-1:0] row_data
);

  logic [ChunkW-1:0] asm_r, asm_nxt;
  logic [ChunkW-1:0] merged;
  logic              row_we;

  // Insert the new byte into the partial row; a full row goes to the RAM.
  always_comb begin
    merged = asm_r;
    merged[{cmd.pos, 3'b000} +: 8] = cmd.data;
    row_we  = cmd.append && (cmd.pos == RowW'(ChunkBytes - 1));
    asm_nxt = asm_r;
    if (cmd.start) begin
      asm_nxt = {{(ChunkW - 8){1'b0}}, cmd.data};
    end else if (cmd.append) begin
      asm_nxt = row_we ? '0 : merged;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

  assign part_chunk = asm_r;

  exlex_ram #(
    .Width(ChunkW),
    .Depth(IdentRows)
  ) u_rows (
    .clk  (clk),
    .we   (row_we),
    .waddr(cmd.row),
    .wdata(merged),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_row),
    .rdata(row_data)
  );

endmodule

/* test/expression_lexer_top_tb.sv */
// Self-checking testbench for expression_lexer_top: drives text bytes, predicts the token stream
// in a scoreboard class and compares every token field by field.
// Depends on exlex_pkg and the expression_lexer_top RTL only.
`timescale 1ns / 100ps

module expression_lexer_top_tb;
  import exlex_pkg::*;

  // Source characters that the lexer knows by name.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQUAL  = "=";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [39:0] KEYWORD_PRINT = "print";

  localparam logic [7:0] PUNCT [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL,
                                        CH_LPAREN, CH_RPAREN, CH_LF, CH_NUL, CH_NUL};
  localparam logic [7:0] BLANKS [3] = '{CH_SPACE, CH_TAB, CH_CR};

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] value;
    logic [63:0]        chunk;
    logic [3:0]         nbytes;
    logic               last;
  } token_t;

  function automatic logic is_decimal(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  // Token predictor and expected-token store.
  class lexer_scoreboard;
    token_t      queued_tokens[$];
    token_t      fresh[$];
    logic [1:0]  mode;
    logic [31:0] acc;
    logic [7:0]  store [MaxIdentLen];
    int          len;
    bit          skipping;
    int          errors, checked, chunks, overlong;

    function new();
      mode = MODE_IDLE;
      acc = '0;
      len = 0;
      skipping = 1'b0;
    endfunction

    function int pending();
      return queued_tokens.size();
    endfunction

    function void push_token(logic [3:0] kind, logic [31:0] value, logic [63:0] chunk,
                             logic [3:0] nbytes);
      token_t t;
      t.kind = kind;
      t.value = value;
      t.chunk = chunk;
      t.nbytes = nbytes;
      t.last = 1'b0;
      fresh.push_back(t);
    endfunction

    // Flags the final token of this byte and moves the batch into the expected store.
    function void commit();
      if (fresh.size() == 0) return;
      fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) queued_tokens.push_back(fresh[i]);
    endfunction

    // Works out the tokens that one accepted byte causes.
    function void note_input(logic [7:0] b);
      logic [63:0] chunk;
      int cnt;
      fresh.delete();
      if (mode == MODE_HALT) return;

      // A pending run either absorbs the byte or is closed by it.
      if (mode == MODE_NUM) begin
        if (is_decimal(b)) begin
          acc = acc * 32'd10 + 32'(b - CH_ZERO);
          return;
        end
        push_token(K_NUMBER, acc, '0, '0);
        acc = '0;
        mode = MODE_IDLE;
      end else if (mode == MODE_IDENT) begin
        if (is_decimal(b) || is_letter(b)) begin
          if (skipping) return;
          if (len < MaxIdentLen) begin
            store[len] = b;
            len++;
            return;
          end
          push_token(K_TOOLONG, '0, '0, '0);
          skipping = 1'b1;
          len = 0;
          commit();
          return;
        end
        if (!skipping) begin
          if (len == 5 && {store[0], store[1], store[2], store[3], store[4]} == KEYWORD_PRINT) begin
            push_token(K_PRINT, '0, '0, '0);
          end else begin
            for (int off = 0; off < len; off += 8) begin
              chunk = '0;
              cnt = 0;
              for (int k = 0; k < 8 && off + k < len; k++) begin
                chunk[8*k +: 8] = store[off + k];
                cnt++;
              end
              push_token(K_IDENT, '0, chunk, 4'(cnt));
            end
          end
        end
        skipping = 1'b0;
        len = 0;
        mode = MODE_IDLE;
      end

      // The byte itself, lexed between tokens.
      if (is_decimal(b)) begin
        acc = 32'(b - CH_ZERO);
        mode = MODE_NUM;
      end else if (is_letter(b)) begin
        store[0] = b;
        len = 1;
        skipping = 1'b0;
        mode = MODE_IDENT;
      end else begin
        case (b)
          CH_SPACE, CH_TAB, CH_CR: ;
          CH_PLUS:   push_token(K_PLUS, '0, '0, '0);
          CH_MINUS:  push_token(K_MINUS, '0, '0, '0);
          CH_STAR:   push_token(K_STAR, '0, '0, '0);
          CH_SLASH:  push_token(K_SLASH, '0, '0, '0);
          CH_EQUAL:  push_token(K_EQUAL, '0, '0, '0);
          CH_LPAREN: push_token(K_LPAREN, '0, '0, '0);
          CH_RPAREN: push_token(K_RPAREN, '0, '0, '0);
          CH_LF:     push_token(K_NEWLINE, '0, '0, '0);
          CH_NUL:    push_token(K_EOF, '0, '0, '0);
          default: begin
            push_token(K_BADCHAR, {24'd0, b}, '0, '0);
            mode = MODE_HALT;
          end
        endcase
      end
      commit();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compares one transferred token with the oldest expected one.
    task check_result(token_t got);
      token_t want;
      if (queued_tokens.size() == 0) begin
        report($sformatf("token kind %0d arrived with nothing expected", got.kind));
        return;
      end
      want = queued_tokens.pop_front();
      checked++;
      if (want.kind == K_IDENT) chunks++;
      if (want.kind == K_TOOLONG) overlong++;
      if (got.kind !== want.kind)
        report($sformatf("token_kind got %0d, expected %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("number_value got %0d, expected %0d", got.value, want.value));
      if (got.chunk !== want.chunk)
        report($sformatf("text_chunk got %h, expected %h", got.chunk, want.chunk));
      if (got.nbytes !== want.nbytes)
        report($sformatf("chunk_bytes got %0d, expected %0d", got.nbytes, want.nbytes));
      if (got.last !== want.last)
        report($sformatf("last_of_run got %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_text_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_token_kind;
  logic signed [31:0] out_number_value;
  logic [63:0]        out_text_chunk;
  logic [3:0]         out_chunk_bytes;
  logic               out_last_of_run;

  lexer_scoreboard sb;
  token_t          seen;
  int              sent;
  int              send_calm;
  int              stall_hold;
  int              stall_calm;
  logic [7:0]      halt_byte;

  expression_lexer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_text_chunk   (out_text_chunk),
    .out_chunk_bytes  (out_chunk_bytes),
    .out_last_of_run  (out_last_of_run)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure: mostly none, often short stalls, a few long ones, and quiet stretches.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (stall_calm > 0) begin
      stall_calm--;
      out_stall <= 1'b0;
    end else if (r < 4) begin
      stall_calm = $urandom_range(20, 200);
      out_stall <= 1'b0;
    end else if (r < 65) begin
      out_stall <= 1'b0;
    end else if (r < 97) begin
      stall_hold = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      stall_hold = $urandom_range(10, 30);
      out_stall <= 1'b1;
    end
  end

  // Every token transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind = out_token_kind;
      seen.value = out_number_value;
      seen.chunk = out_text_chunk;
      seen.nbytes = out_chunk_bytes;
      seen.last = out_last_of_run;
      sb.check_result(seen);
    end
  end

  // Sender idle length: mostly none, sometimes short, rarely long, with gap-free stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    if (r < 3) begin
      send_calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one byte and holds it until the transfer happens.
  task send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    sent++;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the sender off until every expected token has been transferred.
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  task send_ident(int n);
    send_byte(rand_letter());
    for (int i = 1; i < n; i++)
      send_byte($urandom_range(0, 2) == 0 ? 8'($urandom_range("0", "9")) : rand_letter());
  endtask

  task send_number(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range("0", "9")));
  endtask

  initial begin
    int r;
    int next_drain;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: keyword, every operator but plus, a two-chunk identifier, skipped blanks, repeated eof.
    send_text("print(x)=4*7-9/Abcdefghz\n\t");
    send_byte(CH_CR);
    send_byte(CH_NUL);
    send_byte(CH_NUL);

    // Identifiers at the length limit and one byte over it.
    send_ident(MaxIdentLen);
    send_byte(CH_SPACE);
    send_ident(MaxIdentLen + 1);
    send_byte(CH_PLUS);

    // Random token streams with random content, separators and occasional noise.
    next_drain = 160;
    while (sent < 480) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_number($urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6));
      end else if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 10) send_text("print");
        else if (r < 15) send_ident($urandom_range(MaxIdentLen - 3, MaxIdentLen + 3));
        else if (r < 20) send_ident($urandom_range(MaxIdentLen + 4, 100));
        else send_ident($urandom_range(1, 17));
      end else if (r < 80) begin
        send_byte(PUNCT[$urandom_range(0, 9)]);
      end else if (r < 95) begin
        send_byte(BLANKS[$urandom_range(0, 2)]);
      end else begin
        send_text($urandom_range(0, 1) ? "prin" : "printx");
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += 160;
      end
    end

    // An open identifier closed by an unknown byte, then bytes the halted lexer ignores.
    send_text("ab");
    do halt_byte = 8'($urandom_range(0, 255));
    while (is_decimal(halt_byte) || is_letter(halt_byte) ||
           halt_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                             CH_EQUAL, CH_LPAREN, CH_RPAREN, CH_LF, CH_NUL});
    send_byte(halt_byte);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'hFF);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Lexed %0d bytes into %0d checked tokens: %0d identifier chunks, %0d overlong",
             sent, sb.checked, sb.chunks, sb.overlong);
    $display("identifiers; the run ended halted on unknown byte 8'h%02h.", halt_byte);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
rtl/core/exlex_pkg.sv
rtl/core/exlex_ram.sv
rtl/core/exlex_ident_buf.sv
rtl/core/expression_lexer_top.sv
test/expression_lexer_top_tb.sv
